FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/pfargb_pkg.sv
// Types, constants and helpers for the pixel format to ARGB converter.
package pfargb_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned DEPTH_W  = 6;
	localparam int unsigned FMT_W    = 9;
	localparam int unsigned OFF_W    = 5;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 9;

	localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
	localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

	localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic [DEPTH_W-1:0] DEPTH_RST = 6'd16;
	localparam logic [FMT_W-1:0]   RED_RST   = 9'd171;
	localparam logic [FMT_W-1:0]   GREEN_RST = 9'd197;
	localparam logic [FMT_W-1:0]   BLUE_RST  = 9'd160;
	localparam logic [FMT_W-1:0]   ALPHA_RST = 9'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_DEPTH  = 3'd0,
		REG_RED_FORMAT   = 3'd1,
		REG_GREEN_FORMAT = 3'd2,
		REG_BLUE_FORMAT  = 3'd3,
		REG_ALPHA_FORMAT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pixel_byte_0;
		logic [7:0] pixel_byte_1;
		logic [7:0] pixel_byte_2;
		logic [7:0] pixel_byte_3;
	} in_t;

	typedef struct packed {
		logic [7:0] alpha_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       depth_error;
	} out_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] pixel_depth;
		logic [FMT_W-1:0]   red_format;
		logic [FMT_W-1:0]   green_format;
		logic [FMT_W-1:0]   blue_format;
		logic [FMT_W-1:0]   alpha_format;
	} fmt_cfg_t;

	// Field length with codes above eight saturated to eight.
	function automatic logic [LEN_W-1:0] fmt_length(input logic [FMT_W-1:0] fmt);
		logic [LEN_W-1:0] len;
		len = fmt[FMT_W-1:OFF_W];
		return (len > LEN_MAX) ? LEN_MAX : len;
	endfunction

endpackage

FILE: rtl/pfargb_channel.sv
// Extracts one bit field from the pixel word and left-aligns it to 8 bits.
module pfargb_channel (
	input  logic [pfargb_pkg::WORD_W-1:0] word,
	input  logic [pfargb_pkg::FMT_W-1:0]  fmt,
	output logic [pfargb_pkg::CHAN_W-1:0] chan
);

	logic [pfargb_pkg::OFF_W-1:0]  off;
	logic [pfargb_pkg::LEN_W-1:0]  len;
	logic [pfargb_pkg::WORD_W-1:0] shifted;
	logic [pfargb_pkg::CHAN_W:0]   mask9;
	logic [pfargb_pkg::CHAN_W-1:0] field;
	logic [pfargb_pkg::LEN_W-1:0]  pad;

	always_comb begin
		off     = fmt[pfargb_pkg::OFF_W-1:0];
		len     = pfargb_pkg::fmt_length(fmt);
		shifted = word >> off;
		mask9   = (9'd1 << len) - 9'd1;
		field   = shifted[pfargb_pkg::CHAN_W-1:0] & mask9[pfargb_pkg::CHAN_W-1:0];
		pad     = pfargb_pkg::LEN_MAX - len;
		chan    = field << pad;
	end

endmodule

FILE: rtl/pfargb_convert.sv
// Pixel word assembly, depth check and the four channel extractors.
module pfargb_convert (
	input  pfargb_pkg::in_t      pix,
	input  pfargb_pkg::fmt_cfg_t cfg,
	output pfargb_pkg::out_t     res
);

	logic [pfargb_pkg::WORD_W-1:0] word;
	logic                          is16;
	logic                          is32;
	logic [pfargb_pkg::CHAN_W-1:0] red;
	logic [pfargb_pkg::CHAN_W-1:0] green;
	logic [pfargb_pkg::CHAN_W-1:0] blue;
	logic [pfargb_pkg::CHAN_W-1:0] alpha;

	always_comb begin
		is16 = (cfg.pixel_depth == pfargb_pkg::DEPTH_16);
		is32 = (cfg.pixel_depth == pfargb_pkg::DEPTH_32);
		// upper bytes read as zero outside 32-bit mode
		word = {is32 ? pix.pixel_byte_3 : 8'd0, is32 ? pix.pixel_byte_2 : 8'd0,
			pix.pixel_byte_1, pix.pixel_byte_0};
	end

	pfargb_channel u_red   (.word(word), .fmt(cfg.red_format),   .chan(red));
	pfargb_channel u_green (.word(word), .fmt(cfg.green_format), .chan(green));
	pfargb_channel u_blue  (.word(word), .fmt(cfg.blue_format),  .chan(blue));
	pfargb_channel u_alpha (.word(word), .fmt(cfg.alpha_format), .chan(alpha));

	always_comb begin
		res = '0;
		if (is16 || is32) begin
			res.red_out   = red;
			res.green_out = green;
			res.blue_out  = blue;
			res.alpha_out = (pfargb_pkg::fmt_length(cfg.alpha_format) == '0)
				? pfargb_pkg::ALPHA_OPAQUE : alpha;
		end else begin
			res.depth_error = 1'b1;
		end
	end

endmodule

FILE: rtl/pixel_format_to_argb.sv
// Converts framebuffer pixels (16- or 32-bit, little-endian bytes) to 8-bit
// ARGB channels using per-channel offset/length formats. One pixel is taken
// per clock while in_ready is high; a pixel's result reaches the outputs
// through the input register, then the extract and align logic into the
// result register. The input keeps accepting while a result waits, stalling
// only when both the input and result registers are full and out_ready is
// low. Format registers are written through cfg_we/cfg_index/cfg_data and
// should change only while no pixel is in flight.
module pixel_format_to_argb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfargb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfargb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pfargb_pkg::in_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pfargb_pkg::out_t                    out_data
);

	pfargb_pkg::fmt_cfg_t cfg_q;
	pfargb_pkg::in_t      pix_s1;
	logic                 valid_s1;
	pfargb_pkg::out_t     res_s2;
	logic                 valid_s2;
	pfargb_pkg::out_t     res;
	logic                 take_s2;
	logic                 take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_depth  <= pfargb_pkg::DEPTH_RST;
			cfg_q.red_format   <= pfargb_pkg::RED_RST;
			cfg_q.green_format <= pfargb_pkg::GREEN_RST;
			cfg_q.blue_format  <= pfargb_pkg::BLUE_RST;
			cfg_q.alpha_format <= pfargb_pkg::ALPHA_RST;
		end else if (cfg_we) begin
			case (pfargb_pkg::cfg_reg_t'(cfg_index))
				pfargb_pkg::REG_PIXEL_DEPTH:
					cfg_q.pixel_depth <= cfg_data[pfargb_pkg::DEPTH_W-1:0];
				pfargb_pkg::REG_RED_FORMAT:   cfg_q.red_format   <= cfg_data;
				pfargb_pkg::REG_GREEN_FORMAT: cfg_q.green_format <= cfg_data;
				pfargb_pkg::REG_BLUE_FORMAT:  cfg_q.blue_format  <= cfg_data;
				pfargb_pkg::REG_ALPHA_FORMAT: cfg_q.alpha_format <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign take_s2   = !valid_s2 || out_ready;
	assign take_s1   = !valid_s1 || take_s2;
	assign in_ready  = take_s1;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	pfargb_convert u_convert (.pix(pix_s1), .cfg(cfg_q), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= in_valid;
			if (take_s2) valid_s2 <= valid_s1;
		end
	end

	// payload advances with its stage; no reset needed
	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) pix_s1 <= in_data;
		if (take_s2 && valid_s1) res_s2 <= res;
	end

endmodule

FILE: rtl/pfargb_checker.sv
// Port-level checks for the pixel converter, bound to the top level.
`include "assert_macros.svh"

module pfargb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [pfargb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [pfargb_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input pfargb_pkg::in_t                   in_data,
	input logic                              out_valid,
	input logic                              out_ready,
	input pfargb_pkg::out_t                  out_data
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// the input stalls only behind a stalled result
	`ASSERT_IMPL(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready)
	// a depth error blanks every channel
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && out_data.depth_error,
		out_data.alpha_out == 8'd0 && out_data.red_out == 8'd0 &&
		out_data.green_out == 8'd0 && out_data.blue_out == 8'd0)

endmodule

bind pixel_format_to_argb pfargb_checker u_pfargb_checker (.*);
